>>> sv/chained_hash_map_insert_lookup_core_macros.svh
// Assertion macros used by the port-level checker.
`ifndef CHAINED_HASH_MAP_INSERT_LOOKUP_CORE_MACROS_SVH
`define CHAINED_HASH_MAP_INSERT_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("chm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("chm: next-cycle check failed");

`endif

>>> sv/chm_pkg.sv
// Shared types and constants of the chained hash map core.
package chm_pkg;

	localparam int KEY_W = 64;
	localparam int VAL_W = 32;
	localparam int ST_W  = 3;

	typedef enum logic [ST_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_HIT      = 3'd2,
		ST_MISS     = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// main sequencer
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_HEADW,
		S_WALK,
		S_DECIDE,
		S_LINK,
		S_RESP
	} state_t;

	// hash unit
	typedef enum logic [2:0] {
		H_IDLE,
		H_BYTE,
		H_FOLD,
		H_MOD,
		H_DONE
	} hstate_t;

endpackage

>>> sv/chm_if.sv
// Request and response channel interfaces.
interface chm_in_if;
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic [chm_pkg::KEY_W-1:0] key_bits;
	logic [chm_pkg::VAL_W-1:0] entry_value;

	modport source (output valid, output opcode, output key_bits, output entry_value,
		input ready);
	modport sink (input valid, input opcode, input key_bits, input entry_value,
		output ready);
endinterface

interface chm_out_if;
	logic                     valid;
	logic                     ready;
	logic [chm_pkg::ST_W-1:0]  status;
	logic [chm_pkg::VAL_W-1:0] read_value;

	modport source (output valid, output status, output read_value, input ready);
	modport sink (input valid, input status, input read_value, output ready);
endinterface

>>> sv/chained_hash_map_insert_lookup_core.sv
// Chained hash map core: insert and lookup of keys with a times-33 hash.
//
// Channels: req carries opcode (0 insert, 1 lookup), key_bits and entry_value;
// rsp carries status and read_value. A transfer happens when valid and ready
// are both high on a rising clk edge. One request is in flight at a time.
// Each request passes through a byte-serial hash, a read of its bucket head,
// a walk of the chain over the entry RAM at one entry per cycle, a decision,
// a link write for an insert that goes behind an existing entry, and the
// response; when BUCKETS is not a power of two the hash adds a remainder
// reduction. req.ready returns together with rsp.valid, when the result is
// registered in the output register.
// Bucket heads and entries live in two RAMs with registered reads.
// After arst_n releases, the bucket head RAM is swept to empty, one bucket a
// cycle, and req.ready stays low until the sweep is done.
// The result sits in an output register: if the receiver stalls, the next
// request is still taken and processed, and it waits at the end of its walk
// until the held result has been transferred.
module chained_hash_map_insert_lookup_core #(
	parameter int BUCKETS    = 256,
	parameter int CAPACITY   = 1024,
	parameter int KEY_BYTES  = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	chm_in_if.sink    req,
	chm_out_if.source rsp
);
	import chm_pkg::*;

	localparam int KB = 8 * KEY_BYTES;
	localparam int VB = (VALUE_BITS > VAL_W) ? VAL_W : VALUE_BITS;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int EW = KB + VB + LW;
	localparam logic [LW-1:0] CAP = LW'(CAPACITY);
	localparam logic [LW-1:0] ONE = LW'(1);
	localparam logic [BW-1:0] BLAST = BW'(BUCKETS - 1);

	state_t         st_q, st_d;
	logic           acc;
	op_t            op_q;
	logic [KB-1:0]  key_q, tkey_q;
	logic [VB-1:0]  val_q, tval_q, rv_q;
	logic [BW-1:0]  bkt_q, clr_q;
	logic [LW-1:0]  link_q, tail_q, used_q;
	logic           found_q;
	status_t        stat_q, dec_stat;
	logic           ov_q;
	status_t        ost_q;
	logic [VB-1:0]  orv_q;
	logic           out_free;

	logic           hash_done;
	logic [BW-1:0]  hash_bkt;

	logic           hd_we;
	logic [BW-1:0]  hd_waddr, hd_raddr;
	logic [LW-1:0]  hd_wdata, hd_rdata;
	logic           en_we;
	logic [AW-1:0]  en_waddr, en_raddr;
	logic [EW-1:0]  en_wdata, en_rdata;

	logic [LW-1:0]  e_link;
	logic [VB-1:0]  e_val;
	logic [KB-1:0]  e_key;
	logic           e_hit, hd_ok, nx_ok, full;

	chm_hash #(.KEY_BYTES(KEY_BYTES), .BUCKETS(BUCKETS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (acc),
		.key    (req.key_bits[KB-1:0]),
		.done   (hash_done),
		.bucket (hash_bkt)
	);

	chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
		.clk   (clk),
		.we    (hd_we),
		.waddr (hd_waddr),
		.wdata (hd_wdata),
		.raddr (hd_raddr),
		.rdata (hd_rdata)
	);

	chm_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entries (
		.clk   (clk),
		.we    (en_we),
		.waddr (en_waddr),
		.wdata (en_wdata),
		.raddr (en_raddr),
		.rdata (en_rdata)
	);

	// entry word: {key, value, link}
	assign e_link = en_rdata[LW-1:0];
	assign e_val  = en_rdata[LW +: VB];
	assign e_key  = en_rdata[LW + VB +: KB];
	assign e_hit  = (e_key == key_q);
	assign hd_ok  = (hd_rdata != '0) && (hd_rdata <= used_q);
	assign nx_ok  = (e_link != '0) && (e_link <= used_q);
	assign full   = (used_q == CAP);

	assign acc      = req.valid && req.ready;
	assign out_free = !ov_q || rsp.ready;

	always_comb begin
		if (op_q == OP_LOOKUP) begin
			dec_stat = found_q ? ST_HIT : ST_MISS;
		end else if (found_q) begin
			dec_stat = ST_PRESENT;
		end else if (full) begin
			dec_stat = ST_FULL;
		end else begin
			dec_stat = ST_INSERTED;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_CLEAR:  if (clr_q == BLAST) st_d = S_IDLE;
			S_IDLE:   if (acc) st_d = S_HASH;
			S_HASH:   if (hash_done) st_d = S_HEADW;
			S_HEADW:  st_d = hd_ok ? S_WALK : S_DECIDE;
			S_WALK:   if (e_hit || !nx_ok) st_d = S_DECIDE;
			S_DECIDE: begin
				if (dec_stat == ST_INSERTED && tail_q != '0) begin
					st_d = S_LINK;
				end else begin
					st_d = S_RESP;
				end
			end
			S_LINK:   st_d = S_RESP;
			S_RESP:   if (out_free) st_d = S_IDLE;
			default:  st_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (st_q == S_IDLE);
		hd_we     = 1'b0;
		hd_waddr  = bkt_q;
		hd_wdata  = '0;
		hd_raddr  = hash_bkt;
		en_we     = 1'b0;
		en_waddr  = AW'(used_q);
		en_wdata  = {key_q, val_q, LW'(0)};
		en_raddr  = '0;
		case (st_q)
			S_CLEAR: begin
				hd_we    = 1'b1;
				hd_waddr = clr_q;
			end
			S_HEADW:  en_raddr = AW'(hd_rdata - ONE);
			S_WALK:   en_raddr = AW'(e_link - ONE);
			S_DECIDE: begin
				if (dec_stat == ST_INSERTED) begin
					en_we = 1'b1;
					if (tail_q == '0) begin
						hd_we    = 1'b1;
						hd_wdata = used_q + ONE;
					end
				end
			end
			S_LINK: begin
				// used_q already holds the new entry's index + 1
				en_we    = 1'b1;
				en_waddr = AW'(tail_q - ONE);
				en_wdata = {tkey_q, tval_q, used_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_CLEAR;
			clr_q  <= '0;
			used_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == S_CLEAR) begin
				clr_q <= clr_q + BW'(1);
			end
			if (st_q == S_DECIDE && dec_stat == ST_INSERTED) begin
				used_q <= used_q + ONE;
			end
			if (st_q == S_RESP && out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (acc) begin
					op_q    <= op_t'(req.opcode);
					key_q   <= req.key_bits[KB-1:0];
					val_q   <= req.entry_value[VB-1:0];
					tail_q  <= '0;
					found_q <= 1'b0;
					rv_q    <= '0;
				end
			end
			S_HASH: if (hash_done) bkt_q <= hash_bkt;
			S_HEADW: link_q <= hd_rdata;
			S_WALK: begin
				if (e_hit) begin
					found_q <= 1'b1;
					// only a lookup hit returns the stored value
					rv_q    <= (op_q == OP_LOOKUP) ? e_val : '0;
				end else begin
					tail_q <= link_q;
					tkey_q <= e_key;
					tval_q <= e_val;
					link_q <= e_link;
				end
			end
			S_DECIDE: stat_q <= dec_stat;
			S_RESP: begin
				if (out_free) begin
					ost_q <= stat_q;
					orv_q <= rv_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid      = ov_q;
	assign rsp.status     = ost_q;
	assign rsp.read_value = VAL_W'(orv_q);

endmodule

>>> sv/chm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/chm_hash.sv
// Times-33 key hash, one byte per cycle, then fold and bucket reduction.
module chm_hash #(
	parameter int KEY_BYTES = 8,
	parameter int BUCKETS   = 256,
	localparam int KB = 8 * KEY_BYTES,
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [KB-1:0] key,
	output logic          done,
	output logic [BW-1:0] bucket
);
	import chm_pkg::*;

	localparam int CW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
	localparam logic [BW:0] BKT = (BW + 1)'(BUCKETS);
	localparam logic [CW-1:0] LAST = CW'(KEY_BYTES - 1);

	hstate_t        st_q, st_d;
	logic [31:0]    h_q;
	logic [31:0]    h_byte;
	logic [KB-1:0]  key_q;
	logic [CW-1:0]  cnt_q;
	logic [2:0]     mcnt_q;
	logic [BW-1:0]  rem_q;
	logic [BW-1:0]  rem_d;

	assign h_byte = (h_q << 5) + h_q + {24'd0, key_q[7:0]};

	// four restoring remainder steps per cycle, hash MSB first
	always_comb begin
		logic [BW:0]   t;
		logic [BW-1:0] r;
		r = rem_q;
		t = '0;
		for (int i = 0; i < 4; i++) begin
			t = {r, h_q[31-i]};
			if (t >= BKT) begin
				t = t - BKT;
			end
			r = t[BW-1:0];
		end
		rem_d = r;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			H_IDLE: if (start) st_d = H_BYTE;
			H_BYTE: if (cnt_q == LAST) st_d = H_FOLD;
			H_FOLD: st_d = IS_POW2 ? H_DONE : H_MOD;
			H_MOD:  if (mcnt_q == 3'd7) st_d = H_DONE;
			H_DONE: st_d = H_IDLE;
			default: st_d = H_IDLE;
		endcase
	end

	always_comb begin
		done   = (st_q == H_DONE);
		bucket = IS_POW2 ? h_q[BW-1:0] : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= H_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			H_IDLE: begin
				if (start) begin
					key_q  <= key;
					h_q    <= '0;
					cnt_q  <= '0;
					mcnt_q <= '0;
					rem_q  <= '0;
				end
			end
			H_BYTE: begin
				h_q   <= h_byte;
				key_q <= key_q >> 8;
				cnt_q <= cnt_q + CW'(1);
			end
			H_FOLD: h_q <= h_q + (h_q >> 5);
			H_MOD: begin
				rem_q  <= rem_d;
				h_q    <= h_q << 4;
				mcnt_q <= mcnt_q + 3'd1;
			end
			default: ;
		endcase
	end

endmodule

>>> sv/chm_check.sv
// Port-level checker for the hash map core, bound to the top level.
`include "chained_hash_map_insert_lookup_core_macros.svh"

module chm_check (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic [chm_pkg::ST_W-1:0]  status,
	input logic [chm_pkg::VAL_W-1:0] read_value
);
	import chm_pkg::*;

	// one request in flight: no transfer on the cycle after a transfer
	`CHM_ASSERT_NXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)
	`CHM_ASSERT_IMP(a_status_range, clk, arst_n, rsp_valid, status <= ST_FULL)
	`CHM_ASSERT_IMP(a_value_zero, clk, arst_n, rsp_valid && status != ST_HIT, read_value == '0)
	`CHM_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status))

endmodule

bind chained_hash_map_insert_lookup_core chm_check u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.read_value (rsp.read_value)
);

>>> test/chained_hash_map_insert_lookup_core_tb.sv
// Self-checking testbench of the chained hash map core: directed and random inserts/lookups.
module chained_hash_map_insert_lookup_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import chm_pkg::*;

	localparam int BUCKETS     = 256;
	localparam int CAPACITY    = 1024;
	localparam int KEY_BYTES   = 8;
	localparam int BUCKET_W    = $clog2(BUCKETS);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 100;
	localparam int HOLD_SPAN   = 400;
	localparam int MAX_REPORTS = 100;

	typedef struct {
		status_t          status;
		logic [VAL_W-1:0] read_value;
	} map_result_t;

	logic clk;
	logic arst_n;

	chm_in_if  req_ch ();
	chm_out_if rsp_ch ();

	chained_hash_map_insert_lookup_core #(
		.BUCKETS    (BUCKETS),
		.CAPACITY   (CAPACITY),
		.KEY_BYTES  (KEY_BYTES),
		.VALUE_BITS (VAL_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predicted map contents
	logic [VAL_W-1:0] stored_value [logic [KEY_W-1:0]];
	logic [KEY_W-1:0] present_keys [$];
	int unsigned      entries_used;

	map_result_t pending_results [$];
	map_result_t oldest;

	int          error_count;
	int unsigned cycle_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic logic [BUCKET_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
		logic [31:0] h;
		h = '0;
		for (int i = 0; i < KEY_BYTES; i++)
			h = h * 32'd33 + 32'(key[8*i +: 8]);
		h = h + (h >> 5);
		return BUCKET_W'(h % BUCKETS);
	endfunction

	function automatic map_result_t predict_request(input op_t op, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val);
		map_result_t res;
		res.read_value = '0;
		if (op == OP_LOOKUP) begin
			if (stored_value.exists(key)) begin
				res.status     = ST_HIT;
				res.read_value = stored_value[key];
			end else begin
				res.status = ST_MISS;
			end
		end else if (stored_value.exists(key)) begin
			res.status = ST_PRESENT;
		end else if (entries_used >= CAPACITY) begin
			res.status = ST_FULL;
		end else begin
			stored_value[key] = val;
			present_keys.push_back(key);
			entries_used++;
			res.status = ST_INSERTED;
		end
		return res;
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] key;
		do
			key = {$urandom, $urandom};
		while (stored_value.exists(key));
		return key;
	endfunction

	// absent key that lands in the given bucket, to lengthen one chain
	function automatic logic [KEY_W-1:0] colliding_key(input logic [BUCKET_W-1:0] bucket);
		logic [KEY_W-1:0] key;
		do
			key = {$urandom, $urandom};
		while (bucket_of(key) != bucket || stored_value.exists(key));
		return key;
	endfunction

	function automatic logic [KEY_W-1:0] pick_present_key();
		return present_keys[$urandom_range(present_keys.size() - 1)];
	endfunction

	// valid is left high after the transfer; the next call replaces the request or idles it low, and a drain lowers it
	task automatic send_request(input op_t op, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= op;
		req_ch.key_bits    <= key;
		req_ch.entry_value <= val;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		pending_results.push_back(predict_request(op, key, val));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		logic [KEY_W-1:0] chain_keys [4];
		logic [BUCKET_W-1:0] zero_bucket;
		send_idle_pct  = 10;
		recv_stall_pct = 49;
		zero_bucket    = bucket_of('0);
		send_request(OP_LOOKUP, '0, '0);
		send_request(OP_INSERT, '0, '0);
		send_request(OP_INSERT, '1, '1);
		send_request(OP_INSERT, '0, 32'hDEAD_BEEF);
		send_request(OP_LOOKUP, '0, '1);
		send_request(OP_LOOKUP, '1, '0);
		send_request(OP_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
		send_request(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
		send_request(OP_LOOKUP, 64'h5555_5555_5555_5555, '0);
		send_request(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0);
		send_request(OP_LOOKUP, 64'h8000_0000_0000_0000, '0);
		// chain behind key zero
		foreach (chain_keys[i]) begin
			chain_keys[i] = colliding_key(zero_bucket);
			send_request(OP_INSERT, chain_keys[i], $urandom);
		end
		send_request(OP_LOOKUP, chain_keys[3], '0);
		send_request(OP_LOOKUP, chain_keys[1], '0);
		send_request(OP_INSERT, chain_keys[2], $urandom);
		send_request(OP_LOOKUP, colliding_key(zero_bucket), '0);
		send_request(OP_LOOKUP, 64'h0000_0000_0000_0001, '0);
		wait_drained();
	endtask

	task automatic test_random_mix(input int sender_pct, input int receiver_pct,
			input int count);
		logic [BUCKET_W-1:0] hot_bucket;
		int unsigned pick;
		hot_bucket     = BUCKET_W'($urandom_range(BUCKETS - 1));
		send_idle_pct  = sender_pct;
		recv_stall_pct = receiver_pct;
		repeat (count) begin
			pick = $urandom_range(99);
			if (present_keys.size() == 0 || pick < 35)
				send_request(OP_INSERT, fresh_key(), $urandom);
			else if (pick < 45)
				send_request(OP_INSERT, colliding_key(hot_bucket), $urandom);
			else if (pick < 55)
				send_request(OP_INSERT, pick_present_key(), $urandom);
			else if (pick < 85)
				send_request(OP_LOOKUP, pick_present_key(), $urandom);
			else if (pick < 93)
				send_request(OP_LOOKUP, fresh_key(), $urandom);
			else
				send_request(OP_LOOKUP, colliding_key(hot_bucket), $urandom);
		end
		wait_drained();
	endtask

	// receiver holds off while requests keep coming, so the core stalls its input
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = HOLD_SPAN;
		for (int n = 0; n < 8; n++) begin
			if (n % 2 == 0)
				send_request(OP_INSERT, fresh_key(), $urandom);
			else
				send_request(OP_LOOKUP, pick_present_key(), $urandom);
		end
		wait_drained();
	endtask

	task automatic test_full_store();
		logic [KEY_W-1:0] last_key;
		send_idle_pct  = 5;
		recv_stall_pct = 10;
		while (entries_used < CAPACITY) begin
			last_key = fresh_key();
			send_request(OP_INSERT, last_key, $urandom);
		end
		repeat (3)
			send_request(OP_INSERT, fresh_key(), $urandom);
		send_request(OP_INSERT, colliding_key(bucket_of(last_key)), $urandom);
		// an existing key still reports present once full
		send_request(OP_INSERT, last_key, $urandom);
		repeat (3)
			send_request(OP_INSERT, pick_present_key(), $urandom);
		send_request(OP_LOOKUP, last_key, '0);
		send_request(OP_LOOKUP, '0, '0);
		repeat (2)
			send_request(OP_LOOKUP, fresh_key(), $urandom);
		repeat (5)
			send_request(OP_LOOKUP, pick_present_key(), $urandom);
		wait_drained();
	endtask

	initial begin : rsp_side
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with no request outstanding");
			end else begin
				oldest = pending_results.pop_front();
				if (rsp_ch.status !== oldest.status)
					report_mismatch($sformatf("status %0d, expected %s",
						rsp_ch.status, oldest.status.name()));
				if (rsp_ch.read_value !== oldest.read_value)
					report_mismatch($sformatf("read_value %h, expected %h",
						rsp_ch.read_value, oldest.read_value));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.opcode      = OP_INSERT;
		req_ch.key_bits    = '0;
		req_ch.entry_value = '0;
		rsp_ch.ready       = 1'b0;
		error_count        = 0;
		cycle_count        = 0;
		entries_used       = 0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		hold_left          = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix(10, 49, 90);
		test_random_mix(49, 10, 90);
		test_random_mix(0, 0, 90);
		test_backpressure();
		test_full_store();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
